[hw/rtl/stir_pkg.sv]
// Package for the sorted table: sizes, operation and status codes, and the
// command and status structs between the controller and the datapath.
// Used by every module of the block.
package stir_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int ST_W  = 2;
  localparam int EC_W  = 5;
  localparam int PC_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic            capture;
    logic            rd_start;
    logic            ins_step;
    logic            ins_last;
    logic            rem_step;
    logic            done;
    logic            inc;
    logic            dec;
    logic            rd_out;
    logic [ST_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            pos_ok;
    logic            less;
    logic            eq;
    logic            found;
    logic            at_first;
    logic            at_last;
    logic            out_free;
  } dp_stat_t;

endpackage

[hw/rtl/sorted_table_insert_remove.sv]
// Top level of the sorted table: ties the controller to the datapath.
// Depends on stir_pkg, stir_ctrl and stir_datapath.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  operation, value, position
//   out      out_valid / out_stall status, entry_count, read_value
//
// A transaction is taken, decoded, then scans entries in turn through the single
// read and single write port of the entry memory, and hands over its result;
// insert and remove scan up to every entry, a read fetches its one entry, and a
// rejected or unused operation skips the scan.
// Reset clears the count and control state; the entry memory is not cleared.
// A finished result waits in the output register under out_stall while the
// next transaction is taken; that one completes once the register is free.
module sorted_table_insert_remove
  import stir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ST_W-1:0]         status,
  output logic [EC_W-1:0]         entry_count,
  output logic signed [VAL_W-1:0] read_value
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  stir_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .operation   (operation),
    .value       (value),
    .position    (position),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .entry_count (entry_count),
    .read_value  (read_value),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

[hw/rtl/stir_ctrl.sv]
// Controller state machine of the sorted table.
// Depends on stir_pkg; drives commands to stir_datapath.
module stir_ctrl
  import stir_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_INSL   = 3'd3;
  localparam logic [2:0] S_REM    = 3'd4;
  localparam logic [2:0] S_RDW    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]      state, state_next;
  logic [ST_W-1:0] res_status, res_status_next;
  logic            res_inc, res_inc_next;
  logic            res_dec, res_dec_next;
  logic            res_rd, res_rd_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_inc_next    = res_inc;
    res_dec_next    = res_dec;
    res_rd_next     = res_rd;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        res_status_next = ST_OK;
        res_inc_next    = 1'b0;
        res_dec_next    = 1'b0;
        res_rd_next     = 1'b0;
        state_next      = S_FINISH;
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              res_status_next = ST_FULL;
            end else if (stat.empty) begin
              state_next = S_INSL;
            end else begin
              cmd.rd_start = 1'b1;
              state_next   = S_INS;
            end
          end
          OP_REMOVE: begin
            if (stat.empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              cmd.rd_start = 1'b1;
              state_next   = S_REM;
            end
          end
          OP_READ: begin
            if (stat.empty) begin
              res_status_next = ST_EMPTY;
            end else if (!stat.pos_ok) begin
              res_status_next = ST_ABSENT;
            end else begin
              cmd.rd_start = 1'b1;
              state_next   = S_RDW;
            end
          end
          OP_NOP: begin
            res_status_next = ST_OK;
          end
          default: begin
            res_status_next = ST_OK;
          end
        endcase
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (stat.less) begin
          res_inc_next = 1'b1;
          state_next   = S_FINISH;
        end else if (stat.at_first) begin
          state_next = S_INSL;
        end
      end
      S_INSL: begin
        cmd.ins_last = 1'b1;
        res_inc_next = 1'b1;
        state_next   = S_FINISH;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (stat.at_last) begin
          if (stat.found || stat.eq) begin
            res_dec_next = 1'b1;
          end else begin
            res_status_next = ST_ABSENT;
          end
          state_next = S_FINISH;
        end
      end
      S_RDW: begin
        res_rd_next = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.done   = 1'b1;
          cmd.inc    = res_inc;
          cmd.dec    = res_dec;
          cmd.rd_out = res_rd;
          cmd.status = res_status;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_inc    <= 1'b0;
      res_dec    <= 1'b0;
      res_rd     <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_inc    <= res_inc_next;
      res_dec    <= res_dec_next;
      res_rd     <= res_rd_next;
    end
  end

endmodule

[hw/rtl/stir_datapath.sv]
// Datapath of the sorted table: entry memory, scan index, count and the
// result register. Depends on stir_pkg; commanded by stir_ctrl.
module stir_datapath
  import stir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [ST_W-1:0]         status,
  output logic [EC_W-1:0]         entry_count,
  output logic signed [VAL_W-1:0] read_value,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat
);

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata;
  logic [OP_W-1:0]         op_reg;
  logic signed [VAL_W-1:0] val_reg;
  logic [POS_W-1:0]        pos_reg;
  logic [CNT_W-1:0]        count, count_next;
  logic [IDX_W-1:0]        idx, idx_next;
  logic [IDX_W-1:0]        last_idx;
  logic                    found;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  assign last_idx = IDX_W'(count - CNT_W'(1));

  assign stat.op       = op_reg;
  assign stat.full     = (count >= CNT_W'(CAPACITY));
  assign stat.empty    = (count == '0);
  assign stat.pos_ok   = (PC_W'(pos_reg) < PC_W'(count));
  assign stat.less     = (rdata < val_reg);
  assign stat.eq       = (rdata == val_reg);
  assign stat.found    = found;
  assign stat.at_first = (idx == '0);
  assign stat.at_last  = (idx == last_idx);
  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx;
    idx_next = idx;
    wr_en    = 1'b0;
    wr_addr  = idx + IDX_W'(1);
    wr_data  = rdata;
    if (cmd.rd_start) begin
      rd_en = 1'b1;
      unique case (op_reg)
        OP_INSERT: rd_addr = last_idx;
        OP_READ:   rd_addr = IDX_W'(pos_reg);
        default:   rd_addr = '0;
      endcase
      idx_next = rd_addr;
    end
    if (cmd.ins_step) begin
      wr_en   = 1'b1;
      wr_addr = idx + IDX_W'(1);
      wr_data = stat.less ? val_reg : rdata;
      if (!stat.less && idx != '0) begin
        rd_en    = 1'b1;
        rd_addr  = idx - IDX_W'(1);
        idx_next = rd_addr;
      end
    end
    if (cmd.ins_last) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = val_reg;
    end
    if (cmd.rem_step) begin
      wr_en   = found;
      wr_addr = idx - IDX_W'(1);
      wr_data = rdata;
      if (idx != last_idx) begin
        rd_en    = 1'b1;
        rd_addr  = idx + IDX_W'(1);
        idx_next = rd_addr;
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.done && cmd.inc) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.done && cmd.dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.capture) begin
      op_reg  <= operation;
      val_reg <= value;
      pos_reg <= position;
    end
    if (cmd.done) begin
      status      <= cmd.status;
      entry_count <= EC_W'(count_next);
      read_value  <= cmd.rd_out ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.rd_start) begin
        found <= 1'b0;
      end else if (cmd.rem_step && stat.eq) begin
        found <= 1'b1;
      end
      if (cmd.done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.done && cmd.inc |-> !stat.full)
    else $error("insert completed into a full table");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> stat.out_free)
    else $error("result register overwritten while held");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !cmd.done |=> $stable(count))
    else $error("count changed outside transaction completion");

endmodule

[dv/sorted_table_insert_remove_tb.sv]
// Self-checking testbench for the sorted table: a directed table of transactions,
// then random ones, checked by an ordered-table predictor or a row's own result.
// Depends on stir_pkg and the sorted_table_insert_remove top level.
module sorted_table_insert_remove_tb;
  import stir_pkg::*;

  localparam int RAND_ITEMS = 1440;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 50;
  localparam int LONG_HOLD = 400;
  localparam int DIR_ROWS = 22;
  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [ST_W-1:0]         st;
    logic [EC_W-1:0]         cnt;
    logic signed [VAL_W-1:0] rd;
  } table_result_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    logic [4:0]              rep;
    logic                    typed;
    table_result_t           exp;
  } table_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = OP_NOP;
  logic signed [VAL_W-1:0] value = '0;
  logic [POS_W-1:0] position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] status;
  logic [EC_W-1:0] entry_count;
  logic signed [VAL_W-1:0] read_value;

  sorted_table_insert_remove dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .entry_count(entry_count),
    .read_value(read_value)
  );

  always #5 clk = ~clk;

  logic signed [VAL_W-1:0] sorted_vals [CAPACITY];
  int fill = 0;
  table_result_t pending [$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_absent = 0;
  int burst_left = 8;
  int cycles = 0;

  table_row_t dir_rows [DIR_ROWS] = '{
    '{OP_READ,   32'sd0,  4'd0,  5'd1,  1'b1, '{ST_EMPTY,  5'd0,  32'sd0}},
    '{OP_REMOVE, 32'sd7,  4'd0,  5'd1,  1'b1, '{ST_EMPTY,  5'd0,  32'sd0}},
    '{OP_NOP,    -32'sd1, 4'd15, 5'd1,  1'b1, '{ST_OK,     5'd0,  32'sd0}},
    '{OP_INSERT, VMAX,    4'd0,  5'd1,  1'b1, '{ST_OK,     5'd1,  32'sd0}},
    '{OP_INSERT, VMIN,    4'd0,  5'd1,  1'b1, '{ST_OK,     5'd2,  32'sd0}},
    '{OP_READ,   32'sd0,  4'd0,  5'd1,  1'b1, '{ST_OK,     5'd2,  VMIN}},
    '{OP_READ,   32'sd0,  4'd1,  5'd1,  1'b1, '{ST_OK,     5'd2,  VMAX}},
    '{OP_READ,   32'sd0,  4'd15, 5'd1,  1'b1, '{ST_ABSENT, 5'd2,  32'sd0}},
    '{OP_REMOVE, 32'sd5,  4'd0,  5'd1,  1'b1, '{ST_ABSENT, 5'd2,  32'sd0}},
    '{OP_INSERT, -32'sd1, 4'd0,  5'd1,  1'b0, '0},
    '{OP_INSERT, -32'sd1, 4'd0,  5'd1,  1'b0, '0},
    '{OP_INSERT, 32'sd0,  4'd0,  5'd1,  1'b0, '0},
    '{OP_REMOVE, -32'sd1, 4'd0,  5'd1,  1'b0, '0},
    '{OP_REMOVE, VMAX,    4'd0,  5'd1,  1'b0, '0},
    '{OP_REMOVE, VMIN,    4'd0,  5'd1,  1'b0, '0},
    '{OP_INSERT, 32'sd100, 4'd0, 5'd14, 1'b0, '0},
    '{OP_INSERT, 32'sd3,  4'd0,  5'd1,  1'b1, '{ST_FULL,   5'd16, 32'sd0}},
    '{OP_READ,   32'sd0,  4'd15, 5'd1,  1'b0, '0},
    '{OP_READ,   32'sd0,  4'd0,  5'd1,  1'b0, '0},
    '{OP_REMOVE, 32'sd0,  4'd0,  5'd1,  1'b0, '0},
    '{OP_READ,   32'sd0,  4'd15, 5'd1,  1'b1, '{ST_ABSENT, 5'd15, 32'sd0}},
    '{OP_NOP,    32'sd0,  4'd0,  5'd1,  1'b0, '0}
  };

  function automatic table_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic signed [VAL_W-1:0] v,
                                             input logic [POS_W-1:0] pos);
    table_result_t r;
    int slot;
    int k;
    r = '0;
    r.st = ST_OK;
    slot = 0;
    case (op)
      OP_INSERT: begin
        if (fill >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          while (slot < fill && sorted_vals[slot] < v) slot++;
          for (k = fill; k > slot; k--) sorted_vals[k] = sorted_vals[k-1];
          sorted_vals[slot] = v;
          fill++;
        end
      end
      OP_REMOVE: begin
        if (fill == 0) begin
          r.st = ST_EMPTY;
        end else begin
          while (slot < fill && sorted_vals[slot] != v) slot++;
          if (slot >= fill) begin
            r.st = ST_ABSENT;
          end else begin
            for (k = slot; k + 1 < fill; k++) sorted_vals[k] = sorted_vals[k+1];
            fill--;
          end
        end
      end
      OP_READ: begin
        if (fill == 0) r.st = ST_EMPTY;
        else if (int'(pos) >= fill) r.st = ST_ABSENT;
        else r.rd = sorted_vals[pos];
      end
      default: ;
    endcase
    r.cnt = EC_W'(fill);
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 15);
        v = v - 8;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = VMIN;
          1: v = VMAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
                       input logic [POS_W-1:0] pos, input logic typed,
                       input table_result_t exp);
    table_result_t pr;
    in_valid <= 1'b1;
    operation <= op;
    value <= v;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pr = apply_op(op, v, pos);
    pending.push_back(typed ? exp : pr);
    sent++;
    if (pr.st == ST_FULL) n_full++;
    if (pr.st == ST_EMPTY) n_empty++;
    if (pr.st == ST_ABSENT) n_absent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    burst_left = $urandom_range(1, 20);
  endtask

  initial begin
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] pos;
    bit growing;
    bit drained_mid;
    int worked;
    int r;
    growing = 1'b1;
    drained_mid = 1'b0;
    worked = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      for (int j = 0; j < dir_rows[i].rep; j++) begin
        offer(dir_rows[i].op, dir_rows[i].val - 3 * j, dir_rows[i].pos,
              dir_rows[i].typed, dir_rows[i].exp);
      end
    end
    drain();
    while (worked < RAND_ITEMS) begin
      if (fill == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (fill == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      if ($urandom_range(0, 49) == 0) growing = ~growing;
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_NOP;
      else if (r < 20) op = OP_READ;
      else if (r < (growing ? 70 : 40)) op = OP_INSERT;
      else op = OP_REMOVE;
      v = pick_value();
      pos = POS_W'($urandom_range(0, 15));
      if (op == OP_REMOVE && fill > 0 && $urandom_range(0, 9) < 7)
        v = sorted_vals[$urandom_range(0, fill - 1)];
      if (op == OP_READ && fill > 0 && $urandom_range(0, 4) != 0)
        pos = POS_W'($urandom_range(0, fill - 1));
      offer(op, v, pos, 1'b0, '0);
      if (op != OP_NOP) worked++;
      if (worked == RAND_ITEMS / 2 && !drained_mid) begin
        drain();
        drained_mid = 1'b1;
      end
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked; %0d refused as full,",
             sent, checked, n_full);
    $display("tb: %0d on an empty table, %0d with value or position not present",
             n_empty, n_absent);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 300;

  always @(posedge clk) begin
    table_result_t exp;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected result status=%0d count=%0d value=%0d",
                   $time, status, entry_count, read_value);
          errors++;
        end else begin
          exp = pending.pop_front();
          if (status !== exp.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.st, status);
            errors++;
          end
          if (entry_count !== exp.cnt) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, exp.cnt, entry_count);
            errors++;
          end
          if (read_value !== exp.rd) begin
            $display("%0t: read_value expected %0d actual %0d", $time, exp.rd, read_value);
            errors++;
          end
        end
        checked++;
        if (checked == next_hold_at) begin
          hold_left = LONG_HOLD;
          next_hold_at += 700;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
